@@ src/lpht_pkg.sv @@
// Shared types and codes for the linear probing hash table.
// No dependencies; used by the top level and the testbench.
`default_nettype none

package lpht_pkg;

    localparam int KEY_W    = 32;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 3;
    localparam int OVAL_W   = 32;

    localparam logic [ACTION_W-1:0] ACT_PUT    = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_GET    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_UPDATED   = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd5;

    // Width of the step counter for the hash reduction mod SLOTS (three steps)
    localparam int MOD_STEP_W = 2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_PROBE,
        S_PUT,
        S_GET_RD,
        S_GET_LAT,
        S_REM_RD,
        S_REM_CP,
        S_REM_PT,
        S_REM_INV,
        S_RESULT
    } t_state;

endpackage

`default_nettype wire

@@ src/lpht_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ src/linear_probe_hash_table.sv @@
// Lookup: each lookup walks the ring one slot per cycle; put and get do one lookup and remove
// does two lookups plus the swap; when SLOTS is not a power of two, each lookup first reduces
// the hash mod SLOTS.
// Flow: one item at a time; the next transfer is taken the cycle after the result is
// registered.
// Reset: synchronous, active low; a clearing pass then empties the slot RAM, during which
// no item is taken.
`default_nettype none

module linear_probe_hash_table #(
    parameter int SLOTS       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [lpht_pkg::ACTION_W-1:0]       i_action,
    input  wire logic [lpht_pkg::KEY_W-1:0]          i_key_hash,
    input  wire logic [lpht_pkg::OVAL_W-1:0]         i_value_in,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic      [lpht_pkg::STATUS_W-1:0]       o_status,
    output logic      [lpht_pkg::OVAL_W-1:0]         o_value_out,
    output logic      [$clog2(SLOTS+1)-1:0]          o_entry_count
);

    localparam int  PW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int  CW   = $clog2(SLOTS + 1);
    localparam int  KW   = lpht_pkg::KEY_W;
    localparam int  VW   = VALUE_WIDTH;
    localparam int  XW   = (VW > lpht_pkg::OVAL_W) ? VW : lpht_pkg::OVAL_W;
    localparam int  SW   = 1 + KW + PW;       // slot entry: {valid, hash, dense position}
    localparam bit  POW2 = ((SLOTS & (SLOTS - 1)) == 0);
    localparam int  BW   = lpht_pkg::MOD_STEP_W;
    // floor(2^32 / SLOTS): the quotient estimate is never high and at most one low
    localparam logic [KW-1:0] RECIP = KW'((64'd1 << KW) / 64'(SLOTS));

    lpht_pkg::t_state r_state, n_state;

    logic [PW-1:0]     r_idx, n_idx;        // slot address being read
    logic [CW-1:0]     r_iss, n_iss;        // probes issued so far
    logic              r_chk, n_chk;        // read data on the slot RAM is to be checked
    logic [PW-1:0]     r_chk_idx, n_chk_idx;
    logic [KW-1:0]     r_tgt, n_tgt;        // hash being looked up
    logic [KW-1:0]     r_shf, n_shf;
    logic [BW-1:0]     r_bit, n_bit;
    logic [KW-1:0]     r_q, n_q;            // quotient estimate of hash / SLOTS
    logic              r_second, n_second;  // second lookup of a remove
    logic              r_hit, n_hit;
    logic [PW-1:0]     r_s, n_s;            // slot of the key
    logic [PW-1:0]     r_p, n_p;            // dense position of the key
    logic [PW-1:0]     r_ls, n_ls;          // slot of the last dense entry
    logic              r_efound, n_efound;
    logic [PW-1:0]     r_eidx, n_eidx;
    logic [lpht_pkg::ACTION_W-1:0] r_act, n_act;
    logic [VW-1:0]     r_val, n_val;
    logic [VW-1:0]     r_vout, n_vout;
    logic [lpht_pkg::STATUS_W-1:0] r_status, n_status;
    logic [CW-1:0]     r_count, n_count;

    logic                          r_out_valid, n_out_valid;
    logic [lpht_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [lpht_pkg::OVAL_W-1:0]   r_out_value, n_out_value;
    logic [CW-1:0]                 r_out_count, n_out_count;

    logic          slot_we;
    logic [PW-1:0] slot_waddr;
    logic [SW-1:0] slot_wdata;
    logic [SW-1:0] slot_rdata;
    logic          dh_we;
    logic [KW-1:0] dh_wdata;
    logic [KW-1:0] dh_rdata;
    logic          vs_we;
    logic [VW-1:0] vs_wdata;
    logic [VW-1:0] vs_rdata;
    logic [PW-1:0] dense_waddr;
    logic [PW-1:0] dense_raddr;

    logic          sl_valid;
    logic [KW-1:0] sl_hash;
    logic [PW-1:0] sl_pos;
    logic [XW-1:0] vin_x;
    logic [XW-1:0] vout_x;
    logic [PW-1:0] last_pos;
    logic [CW-1:0] count_m1;
    logic [2*KW-1:0] recip_prod;
    logic [KW-1:0] q_times;
    logic [KW-1:0] mod_sub;
    logic          start_lk;
    logic [KW-1:0] start_tgt;
    logic [PW-1:0] idx_inc;

    assign sl_valid = slot_rdata[SW-1];
    assign sl_hash  = slot_rdata[SW-2 -: KW];
    assign sl_pos   = slot_rdata[PW-1:0];

    assign vin_x    = XW'(i_value_in);
    assign vout_x   = XW'(r_vout);
    assign count_m1 = r_count - CW'(1);
    assign last_pos = count_m1[PW-1:0];
    assign idx_inc  = (r_idx == PW'(SLOTS - 1)) ? '0 : r_idx + PW'(1);

    assign recip_prod = (2*KW)'(r_shf) * (2*KW)'(RECIP);
    assign q_times    = r_q * KW'(SLOTS);
    assign mod_sub    = (r_shf >= KW'(SLOTS)) ? r_shf - KW'(SLOTS) : r_shf;

    assign o_in_ready    = (r_state == lpht_pkg::S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_value_out   = r_out_value;
    assign o_entry_count = r_out_count;

    assign dense_raddr = (r_state == lpht_pkg::S_REM_RD) ? last_pos : r_p;

    lpht_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (r_idx),
        .o_rdata (slot_rdata)
    );

    lpht_ram #(.WIDTH(KW), .DEPTH(SLOTS)) u_dense_hash_ram (
        .i_clk   (i_clk),
        .i_we    (dh_we),
        .i_waddr (dense_waddr),
        .i_wdata (dh_wdata),
        .i_raddr (dense_raddr),
        .o_rdata (dh_rdata)
    );

    lpht_ram #(.WIDTH(VW), .DEPTH(SLOTS)) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (vs_we),
        .i_waddr (dense_waddr),
        .i_wdata (vs_wdata),
        .i_raddr (dense_raddr),
        .o_rdata (vs_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lpht_pkg::S_CLEAR;
            r_idx       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iss        <= n_iss;
        r_chk        <= n_chk;
        r_chk_idx    <= n_chk_idx;
        r_tgt        <= n_tgt;
        r_shf        <= n_shf;
        r_bit        <= n_bit;
        r_q          <= n_q;
        r_second     <= n_second;
        r_hit        <= n_hit;
        r_s          <= n_s;
        r_p          <= n_p;
        r_ls         <= n_ls;
        r_efound     <= n_efound;
        r_eidx       <= n_eidx;
        r_act        <= n_act;
        r_val        <= n_val;
        r_vout       <= n_vout;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_count  <= n_out_count;
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_iss        = r_iss;
        n_chk        = r_chk;
        n_chk_idx    = r_chk_idx;
        n_tgt        = r_tgt;
        n_shf        = r_shf;
        n_bit        = r_bit;
        n_q          = r_q;
        n_second     = r_second;
        n_hit        = r_hit;
        n_s          = r_s;
        n_p          = r_p;
        n_ls         = r_ls;
        n_efound     = r_efound;
        n_eidx       = r_eidx;
        n_act        = r_act;
        n_val        = r_val;
        n_vout       = r_vout;
        n_status     = r_status;
        n_count      = r_count;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        n_out_count  = r_out_count;

        slot_we     = 1'b0;
        slot_waddr  = r_idx;
        slot_wdata  = '0;
        dh_we       = 1'b0;
        dh_wdata    = r_tgt;
        vs_we       = 1'b0;
        vs_wdata    = r_val;
        dense_waddr = r_p;

        start_lk  = 1'b0;
        start_tgt = r_tgt;

        unique case (r_state)
            lpht_pkg::S_CLEAR: begin
                slot_we    = 1'b1;
                slot_waddr = r_idx;
                n_idx      = idx_inc;
                if (r_idx == PW'(SLOTS - 1)) begin
                    n_state = lpht_pkg::S_IDLE;
                end
            end

            lpht_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_act    = i_action;
                    n_val    = vin_x[VW-1:0];
                    n_vout   = '0;
                    n_second = 1'b0;
                    n_status = lpht_pkg::STAT_NOT_FOUND;
                    if (i_action == lpht_pkg::ACT_PUT || i_action == lpht_pkg::ACT_GET ||
                        i_action == lpht_pkg::ACT_REMOVE) begin
                        start_lk  = 1'b1;
                        start_tgt = i_key_hash;
                    end else begin
                        n_state = lpht_pkg::S_RESULT;
                    end
                end
            end

            // hash mod SLOTS: reciprocal multiply, back-multiply and subtract, then
            // one correcting subtract
            lpht_pkg::S_MOD: begin
                n_bit = r_bit - BW'(1);
                if (r_bit == BW'(2)) begin
                    n_q = recip_prod[2*KW-1:KW];
                end else if (r_bit == BW'(1)) begin
                    n_shf = r_shf - q_times;
                end else begin
                    n_state  = lpht_pkg::S_PROBE;
                    n_idx    = mod_sub[PW-1:0];
                    n_iss    = '0;
                    n_chk    = 1'b0;
                    n_efound = 1'b0;
                end
            end

            // one read issued per cycle; the data of the previous read is checked
            lpht_pkg::S_PROBE: begin
                if (r_iss != CW'(SLOTS)) begin
                    n_chk     = 1'b1;
                    n_chk_idx = r_idx;
                    n_idx     = idx_inc;
                    n_iss     = r_iss + CW'(1);
                end else begin
                    n_chk = 1'b0;
                end
                if (r_chk && !sl_valid && !r_efound) begin
                    n_efound = 1'b1;
                    n_eidx   = r_chk_idx;
                end
                if ((r_chk && sl_valid && sl_hash == r_tgt) ||
                    (!r_chk && r_iss == CW'(SLOTS))) begin
                    n_hit = r_chk;
                    if (r_second) begin
                        n_ls    = r_chk_idx;
                        n_state = lpht_pkg::S_REM_PT;
                    end else begin
                        n_s = r_chk_idx;
                        n_p = sl_pos;
                        case (r_act)
                            lpht_pkg::ACT_PUT: begin
                                n_state = lpht_pkg::S_PUT;
                            end
                            lpht_pkg::ACT_GET: begin
                                n_state = r_chk ? lpht_pkg::S_GET_RD : lpht_pkg::S_RESULT;
                            end
                            default: begin
                                if (!r_chk) begin
                                    n_state = lpht_pkg::S_RESULT;
                                end else if (r_count != '0) begin
                                    n_state = lpht_pkg::S_REM_RD;
                                end else begin
                                    n_state = lpht_pkg::S_REM_INV;
                                end
                            end
                        endcase
                    end
                end
            end

            lpht_pkg::S_PUT: begin
                n_state = lpht_pkg::S_RESULT;
                if (r_hit) begin
                    vs_we       = 1'b1;
                    dense_waddr = r_p;
                    n_status    = lpht_pkg::STAT_UPDATED;
                end else if (r_efound && r_count < CW'(SLOTS)) begin
                    slot_we     = 1'b1;
                    slot_waddr  = r_eidx;
                    slot_wdata  = {1'b1, r_tgt, r_count[PW-1:0]};
                    dh_we       = 1'b1;
                    vs_we       = 1'b1;
                    dense_waddr = r_count[PW-1:0];
                    n_count     = r_count + CW'(1);
                    n_status    = lpht_pkg::STAT_INSERTED;
                end else begin
                    n_status = lpht_pkg::STAT_FULL;
                end
            end

            lpht_pkg::S_GET_RD: begin
                n_state = lpht_pkg::S_GET_LAT;
            end

            lpht_pkg::S_GET_LAT: begin
                n_vout   = vs_rdata;
                n_status = lpht_pkg::STAT_FOUND;
                n_state  = lpht_pkg::S_RESULT;
            end

            lpht_pkg::S_REM_RD: begin
                n_state = lpht_pkg::S_REM_CP;
            end

            // last dense entry fills the hole, then its slot is looked up
            lpht_pkg::S_REM_CP: begin
                dh_we       = 1'b1;
                dh_wdata    = dh_rdata;
                vs_we       = 1'b1;
                vs_wdata    = vs_rdata;
                dense_waddr = r_p;
                n_second    = 1'b1;
                start_lk    = 1'b1;
                start_tgt   = dh_rdata;
            end

            lpht_pkg::S_REM_PT: begin
                if (r_hit) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_ls;
                    slot_wdata = {1'b1, r_tgt, r_p};
                end
                n_state = lpht_pkg::S_REM_INV;
            end

            lpht_pkg::S_REM_INV: begin
                slot_we    = 1'b1;
                slot_waddr = r_s;
                slot_wdata = '0;
                if (r_count != '0) begin
                    n_count = count_m1;
                end
                n_status = lpht_pkg::STAT_REMOVED;
                n_state  = lpht_pkg::S_RESULT;
            end

            lpht_pkg::S_RESULT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_value  = vout_x[lpht_pkg::OVAL_W-1:0];
                    n_out_count  = r_count;
                    n_state      = lpht_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = lpht_pkg::S_IDLE;
            end
        endcase

        if (start_lk) begin
            n_tgt = start_tgt;
            if (POW2) begin
                n_state  = lpht_pkg::S_PROBE;
                n_idx    = start_tgt[PW-1:0];
                n_iss    = '0;
                n_chk    = 1'b0;
                n_efound = 1'b0;
            end else begin
                n_state = lpht_pkg::S_MOD;
                n_shf   = start_tgt;
                n_bit   = BW'(2);
            end
        end
    end

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for linear_probe_hash_table: directed and random put/get/remove
// traffic, checked against a shadow of the slot ring and dense store held in a small class.
// Depends on lpht_pkg and the linear_probe_hash_table RTL.
`timescale 1ns / 100ps

module tb_top;

    localparam int SLOTS       = 16;
    localparam int CNT_W       = $clog2(SLOTS + 1);
    localparam int RAND_ITEMS  = 1450;
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 2 * SLOTS + 30;
    localparam int CYCLE_LIMIT = 500000;
    localparam int POOL_SIZE   = 16;
    localparam int KW          = lpht_pkg::KEY_W;
    localparam int AW          = lpht_pkg::ACTION_W;
    localparam int STW         = lpht_pkg::STATUS_W;
    localparam int OW          = lpht_pkg::OVAL_W;

    // Spare action code: the block must leave everything alone
    localparam logic [AW-1:0] ACT_UNUSED = 2'd3;

    typedef struct {
        logic [STW-1:0]   status;
        logic [OW-1:0]    value;
        logic [CNT_W-1:0] count;
    } t_reply;

    // Shadow of the slot ring and dense store; predicts one reply per transfer in
    class t_probe_table_model;
        logic [KW-1:0] slot_key  [SLOTS];
        bit            slot_used [SLOTS];
        int unsigned   slot_idx  [SLOTS];
        logic [KW-1:0] dense_key [SLOTS];
        logic [OW-1:0] dense_val [SLOTS];
        int unsigned   live;
        t_reply        expected_replies [$];
        int            errors;
        int            requests;
        int            replies;
        int            status_seen [lpht_pkg::STAT_FULL + 1];

        function new();
            for (int i = 0; i < SLOTS; i++) begin
                slot_key[i]  = '0;
                slot_used[i] = 1'b0;
                slot_idx[i]  = 0;
                dense_key[i] = '0;
                dense_val[i] = '0;
            end
            live     = 0;
            errors   = 0;
            requests = 0;
            replies  = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        // Slot holding a live entry with this hash, or SLOTS when absent
        function int find_key(logic [KW-1:0] h);
            int s;
            s = h % SLOTS;
            for (int k = 0; k < SLOTS; k++) begin
                if (slot_used[s] && slot_key[s] == h)
                    return s;
                s = (s + 1) % SLOTS;
            end
            return SLOTS;
        endfunction

        function int first_free(logic [KW-1:0] h);
            int s;
            s = h % SLOTS;
            for (int k = 0; k < SLOTS; k++) begin
                if (!slot_used[s])
                    return s;
                s = (s + 1) % SLOTS;
            end
            return SLOTS;
        endfunction

        function void note_request(logic [AW-1:0] act, logic [KW-1:0] h,
                                   logic [OW-1:0] v);
            t_reply r;
            int     s;
            int     e;
            int     p;
            int     last;
            int     ls;
            r.status = lpht_pkg::STAT_NOT_FOUND;
            r.value  = '0;
            requests++;
            s = find_key(h);
            case (act)
                lpht_pkg::ACT_PUT: begin
                    if (s < SLOTS) begin
                        dense_val[slot_idx[s] % SLOTS] = v;
                        r.status = lpht_pkg::STAT_UPDATED;
                    end else begin
                        e = first_free(h);
                        if (e < SLOTS && live < SLOTS) begin
                            slot_key[e]     = h;
                            slot_used[e]    = 1'b1;
                            slot_idx[e]     = live;
                            dense_key[live] = h;
                            dense_val[live] = v;
                            live++;
                            r.status = lpht_pkg::STAT_INSERTED;
                        end else begin
                            r.status = lpht_pkg::STAT_FULL;
                        end
                    end
                end
                lpht_pkg::ACT_GET: begin
                    if (s < SLOTS) begin
                        r.value  = dense_val[slot_idx[s] % SLOTS];
                        r.status = lpht_pkg::STAT_FOUND;
                    end
                end
                lpht_pkg::ACT_REMOVE: begin
                    if (s < SLOTS) begin
                        p = slot_idx[s] % SLOTS;
                        if (live > 0) begin
                            // last dense entry fills the hole; its slot is repointed
                            last = (live - 1) % SLOTS;
                            ls   = find_key(dense_key[last]);
                            dense_key[p] = dense_key[last];
                            dense_val[p] = dense_val[last];
                            if (ls < SLOTS)
                                slot_idx[ls] = p;
                            live--;
                        end
                        slot_key[s]  = '0;
                        slot_used[s] = 1'b0;
                        r.status = lpht_pkg::STAT_REMOVED;
                    end
                end
                default: ;
            endcase
            r.count = CNT_W'(live);
            expected_replies.push_back(r);
        endfunction

        function void check_reply(logic [STW-1:0] st, logic [OW-1:0] val,
                                  logic [CNT_W-1:0] cnt);
            t_reply r;
            replies++;
            if (st <= lpht_pkg::STAT_FULL)
                status_seen[st]++;
            if (expected_replies.size() == 0) begin
                $error("reply with nothing expected: status %0d value %h count %0d",
                       st, val, cnt);
                errors++;
                return;
            end
            r = expected_replies.pop_front();
            if (st !== r.status) begin
                $error("status: expected %0d, got %0d", r.status, st);
                errors++;
            end
            if (val !== r.value) begin
                $error("value_out: expected %h, got %h", r.value, val);
                errors++;
            end
            if (cnt !== r.count) begin
                $error("entry_count: expected %0d, got %0d", r.count, cnt);
                errors++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             i_in_valid;
    logic             o_in_ready;
    logic [AW-1:0]    i_action;
    logic [KW-1:0]    i_key_hash;
    logic [OW-1:0]    i_value_in;
    logic             o_out_valid;
    logic             i_out_ready;
    logic [STW-1:0]   o_status;
    logic [OW-1:0]    o_value_out;
    logic [CNT_W-1:0] o_entry_count;

    t_probe_table_model shadow = new();

    logic [KW-1:0] key_pool [POOL_SIZE];
    bit            quiet     = 1'b0;
    int            hold_req  = 0;
    int            hold_done = 0;
    int            cycle_cnt = 0;

    linear_probe_hash_table #(
        .SLOTS       (SLOTS),
        .VALUE_WIDTH (32)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_key_hash    (i_key_hash),
        .i_value_in    (i_value_in),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_value_out   (o_value_out),
        .o_entry_count (o_entry_count)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
    end

    initial begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("Some tests failed");
        $finish;
    end

    // Transfers are sampled with pre-edge values on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready)
                shadow.note_request(i_action, i_key_hash, i_value_in);
            if (o_out_valid && i_out_ready)
                shadow.check_reply(o_status, o_value_out, o_entry_count);
        end
    end

    // Receiver: random back-pressure, quiet stretches and one long hold-off
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_done != hold_req) begin
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge i_clk);
                hold_done++;
            end else if (quiet) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= 6);
            end
        end
    end

    task automatic push_item(input logic [AW-1:0] act, input logic [KW-1:0] key,
                             input logic [OW-1:0] val);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 6) begin
            gap = $urandom_range(1, 8);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_action   <= act;
        i_key_hash <= key;
        i_value_in <= val;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (shadow.expected_replies.size() != 0);
    endtask

    // Half the pool shares a few home slots so probe chains form and wrap
    function automatic void refill_pool();
        logic [3:0] home [4] = '{4'h0, 4'h1, 4'he, 4'hf};
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
            if (i < POOL_SIZE / 2)
                key_pool[i][3:0] = home[$urandom_range(0, 3)];
        end
    endfunction

    function automatic logic [KW-1:0] pick_key(int live_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < live_pct && shadow.live > 0)
            return shadow.dense_key[$urandom_range(0, shadow.live - 1)];
        else if (r < 90)
            return key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            return $urandom;
    endfunction

    initial begin
        int            n;
        int            r;
        bit            grow;
        logic [AW-1:0] act;
        logic [KW-1:0] key;
        logic [OW-1:0] val;

        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_action   <= lpht_pkg::ACT_PUT;
        i_key_hash <= '0;
        i_value_in <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, spare code, wrap-around chain, holes in the chain
        push_item(lpht_pkg::ACT_GET,    32'h0000_0000, 32'hffff_ffff);
        push_item(lpht_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0);
        push_item(ACT_UNUSED,           32'hffff_ffff, 32'hffff_ffff);
        push_item(lpht_pkg::ACT_PUT,    32'h0000_0000, 32'hffff_ffff);
        push_item(lpht_pkg::ACT_PUT,    32'hffff_ffff, 32'h0000_0000);
        push_item(lpht_pkg::ACT_PUT,    32'h0000_001f, 32'h5555_5555);
        push_item(lpht_pkg::ACT_PUT,    32'h0000_002f, 32'haaaa_aaaa);
        push_item(lpht_pkg::ACT_GET,    32'h0000_002f, 32'h0);
        push_item(lpht_pkg::ACT_PUT,    32'h0000_0000, 32'h1234_5678);
        push_item(lpht_pkg::ACT_GET,    32'h0000_0000, 32'h0);
        push_item(lpht_pkg::ACT_GET,    32'h0000_0010, 32'h0);
        push_item(lpht_pkg::ACT_REMOVE, 32'h0000_0000, 32'h0);
        // the hole left at the home slot must not hide entries further on
        push_item(lpht_pkg::ACT_GET,    32'h0000_001f, 32'h0);
        push_item(lpht_pkg::ACT_PUT,    32'h0000_001f, 32'h8000_0001);
        push_item(lpht_pkg::ACT_GET,    32'h0000_002f, 32'h0);
        push_item(lpht_pkg::ACT_REMOVE, 32'h0000_002f, 32'h0);
        push_item(ACT_UNUSED,           32'h0000_001f, 32'h0);
        push_item(lpht_pkg::ACT_REMOVE, 32'hffff_ffff, 32'h0);
        push_item(lpht_pkg::ACT_GET,    32'h0000_001f, 32'h0);
        push_item(lpht_pkg::ACT_REMOVE, 32'h0000_001f, 32'h0);
        push_item(lpht_pkg::ACT_REMOVE, 32'h0000_001f, 32'h0);
        push_item(lpht_pkg::ACT_GET,    32'hffff_ffff, 32'h0);
        wait_drained();

        // Random: alternating fill and drain phases so both full and empty are reached
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 300 == 0)
                refill_pool();
            if (n == 400)
                hold_req++;
            if (n == 800)
                wait_drained();
            quiet = (n >= 900 && n < 1100);
            grow  = ((n / 120) % 2 == 0);
            r     = $urandom_range(0, 99);
            if (grow)
                act = (r < 60) ? lpht_pkg::ACT_PUT : (r < 78) ? lpht_pkg::ACT_GET :
                      (r < 95) ? lpht_pkg::ACT_REMOVE : ACT_UNUSED;
            else
                act = (r < 20) ? lpht_pkg::ACT_PUT : (r < 40) ? lpht_pkg::ACT_GET :
                      (r < 95) ? lpht_pkg::ACT_REMOVE : ACT_UNUSED;
            key = pick_key(grow ? 50 : 80);
            r   = $urandom_range(0, 99);
            val = (r < 5) ? '0 : (r < 10) ? '1 : $urandom;
            push_item(act, key, val);
        end
        quiet = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d transfers in, %0d replies; inserted %0d, updated %0d, found %0d,",
                 shadow.requests, shadow.replies,
                 shadow.status_seen[lpht_pkg::STAT_INSERTED],
                 shadow.status_seen[lpht_pkg::STAT_UPDATED],
                 shadow.status_seen[lpht_pkg::STAT_FOUND]);
        $display("removed %0d, not found %0d, full %0d",
                 shadow.status_seen[lpht_pkg::STAT_REMOVED],
                 shadow.status_seen[lpht_pkg::STAT_NOT_FOUND],
                 shadow.status_seen[lpht_pkg::STAT_FULL]);
        if (shadow.errors == 0 && shadow.expected_replies.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ files.f @@
src/lpht_pkg.sv
src/lpht_ram.sv
src/linear_probe_hash_table.sv
tb/tb_top.sv
